// ----- sv/alet_pkg.sv -----
// Shared types and codes for the access-list entry table.
package alet_pkg;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_CALC   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NOMATCH = 2'd2
   } status_code_type;

   localparam logic [2:0] TAG_NAMED_USER   = 3'd1;
   localparam logic [2:0] TAG_OWNING_GROUP = 3'd2;
   localparam logic [2:0] TAG_NAMED_GROUP  = 3'd3;
   localparam logic [2:0] TAG_MASK         = 3'd4;

   typedef struct packed {
      logic [2:0]  tag;
      logic [31:0] id;
      logic [2:0]  perms;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear_count;
      logic rd_en;
      logic rd_next;
      logic ptr_inc;
      logic acc;
      logic wr_match;
      logic wr_append;
      logic wr_shift;
      logic count_dec;
      logic set_full;
      logic set_nomatch;
      logic to_mask_phase;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type act;
      logic       at_end;
      logic       last_shift;
      logic       full;
      logic       hit;
      logic       needed;
      logic       mask_phase;
   } sts_type;

endpackage

// ----- sv/access_list_entry_table.sv -----
// Top level of the access-list entry table.
//
//  Channel    Handshake                Fields
//  request    start, busy              req_action, req_entry_tag, req_entry_id,
//                                      req_entry_perms
//  response   rsp_valid (one cycle)    rsp_status, rsp_entry_count, rsp_mask_perms,
//                                      rsp_mask_needed
//
// A request is taken when start is high and busy is low; one response follows.
// The entry memory has one registered read port, so each scanned entry passes through
// a read state and a check state. An add stops its scan when it finds its entry, and
// a delete that finds its entry shifts each later entry down through a shift-read and
// a shift-write state. Calculate mask scans the whole table and may run an add scan
// for the mask entry. Clear resets the entry count and responds.
// Reset empties the table at once; there is no clearing pass.
// The response cannot be stalled; busy stays high until the response cycle ends.
module access_list_entry_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [2:0]                        req_entry_tag,
   input  logic [31:0]                       req_entry_id,
   input  logic [2:0]                        req_entry_perms,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]  rsp_entry_count,
   output logic [2:0]                        rsp_mask_perms,
   output logic                              rsp_mask_needed
);
   import alet_pkg::*;

   localparam int PW = $clog2(MAX_ENTRIES + 1);

   cmd_type cmd;
   sts_type sts;

   alet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   alet_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_entry_tag   (req_entry_tag),
      .req_entry_id    (req_entry_id),
      .req_entry_perms (req_entry_perms),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_mask_perms  (rsp_mask_perms),
      .rsp_mask_needed (rsp_mask_needed)
   );

   // Checks that the response strobe does not stay high past the response cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transfer");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_entry_count == PW'(MAX_ENTRIES)))
      else $error("table full reported with room left");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= PW'(MAX_ENTRIES)))
      else $error("entry count beyond table size");

   a_mask_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mask_needed) |-> (rsp_mask_perms == 3'd0))
      else $error("mask permissions reported without a mask");

endmodule

// ----- sv/alet_datapath.sv -----
// Entry memory, scan pointer, entry count and result registers.
module alet_datapath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  alet_pkg::cmd_type                    cmd,
   output alet_pkg::sts_type                    sts,
   input  logic [1:0]                           req_action,
   input  logic [2:0]                           req_entry_tag,
   input  logic [31:0]                          req_entry_id,
   input  logic [2:0]                           req_entry_perms,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]     rsp_entry_count,
   output logic [2:0]                           rsp_mask_perms,
   output logic                                 rsp_mask_needed
);
   import alet_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int PW = $clog2(MAX_ENTRIES + 1);
   localparam logic [PW-1:0] MaxCount = PW'(MAX_ENTRIES);

   entry_type   mem [MAX_ENTRIES];
   entry_type   rd_ff;

   action_type  act_ff, act_in;
   logic [2:0]  tag_ff, tag_in;
   logic [31:0] id_ff, id_in;
   logic [2:0]  perms_ff, perms_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] count_ff, count_in;
   status_code_type status_ff, status_in;
   logic [2:0]  mask_ff, mask_in;
   logic        needed_ff, needed_in;
   logic        phase_ff, phase_in;

   logic [PW-1:0] ptr_next;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   logic          id_compared;
   logic          counted_tag;

   assign ptr_next = ptr_ff + PW'(1);
   assign id_compared = (tag_ff == TAG_NAMED_USER) || (tag_ff == TAG_NAMED_GROUP);
   assign counted_tag = (rd_ff.tag == TAG_NAMED_USER) || (rd_ff.tag == TAG_OWNING_GROUP)
                        || (rd_ff.tag == TAG_NAMED_GROUP);

   assign sts.act        = act_ff;
   assign sts.at_end     = (ptr_ff == count_ff);
   assign sts.last_shift = (ptr_next == count_ff);
   assign sts.full       = (count_ff == MaxCount);
   assign sts.hit        = (rd_ff.tag == tag_ff) && (!id_compared || (rd_ff.id == id_ff));
   assign sts.needed     = needed_ff;
   assign sts.mask_phase = phase_ff;

   assign rd_addr = cmd.rd_next ? ptr_next[AW-1:0] : ptr_ff[AW-1:0];

   always_comb begin
      wr_en   = cmd.wr_match || cmd.wr_append || cmd.wr_shift;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = rd_ff;
      if (cmd.wr_match) begin
         wr_data.perms = perms_ff;
      end else if (cmd.wr_append) begin
         wr_addr = count_ff[AW-1:0];
         wr_data = '{tag: tag_ff, id: id_ff, perms: perms_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      act_in    = act_ff;
      tag_in    = tag_ff;
      id_in     = id_ff;
      perms_in  = perms_ff;
      ptr_in    = ptr_ff;
      count_in  = count_ff;
      status_in = status_ff;
      mask_in   = mask_ff;
      needed_in = needed_ff;
      phase_in  = phase_ff;
      if (cmd.load) begin
         act_in    = action_type'(req_action);
         tag_in    = req_entry_tag;
         id_in     = req_entry_id;
         perms_in  = req_entry_perms;
         ptr_in    = '0;
         status_in = STATUS_OK;
         mask_in   = '0;
         needed_in = 1'b0;
         phase_in  = 1'b0;
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.ptr_inc) begin
         ptr_in = ptr_next;
      end
      if (cmd.acc && counted_tag) begin
         mask_in   = mask_ff | rd_ff.perms;
         needed_in = 1'b1;
      end
      if (cmd.wr_append) begin
         count_in = count_ff + PW'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - PW'(1);
      end
      if (cmd.set_full) begin
         status_in = STATUS_FULL;
      end
      if (cmd.set_nomatch) begin
         status_in = STATUS_NOMATCH;
      end
      // The mask entry is inserted by rerunning the add scan on the mask tag.
      if (cmd.to_mask_phase) begin
         act_in   = ACT_ADD;
         tag_in   = TAG_MASK;
         id_in    = '0;
         perms_in = mask_ff;
         ptr_in   = '0;
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      tag_ff    <= tag_in;
      id_ff     <= id_in;
      perms_ff  <= perms_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      needed_ff <= needed_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_mask_perms  = mask_ff;
   assign rsp_mask_needed = needed_ff;

endmodule

// ----- sv/alet_ctrl.sv -----
// Controller state machine that sequences scans, shifts and the response.
module alet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  alet_pkg::sts_type sts,
   output alet_pkg::cmd_type cmd
);
   import alet_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN_RD  = 6'b000010,
      S_SCAN_CHK = 6'b000100,
      S_SHIFT_RD = 6'b001000,
      S_SHIFT_WR = 6'b010000,
      S_RESPOND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (sts.act == ACT_CLEAR) begin
               cmd.clear_count = 1'b1;
               state_in        = S_RESPOND;
            end else if (sts.at_end) begin
               state_in = S_RESPOND;
               case (sts.act)
                  ACT_ADD: begin
                     if (!sts.full) begin
                        cmd.wr_append = 1'b1;
                     end else if (!sts.mask_phase) begin
                        cmd.set_full = 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     cmd.set_nomatch = 1'b1;
                  end
                  ACT_CALC: begin
                     if (sts.needed) begin
                        cmd.to_mask_phase = 1'b1;
                        state_in          = S_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = S_RESPOND;
                  end
               endcase
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            state_in = S_SCAN_RD;
            case (sts.act)
               ACT_CALC: begin
                  cmd.acc     = 1'b1;
                  cmd.ptr_inc = 1'b1;
               end
               ACT_ADD: begin
                  if (sts.hit) begin
                     cmd.wr_match = 1'b1;
                     state_in     = S_RESPOND;
                  end else begin
                     cmd.ptr_inc = 1'b1;
                  end
               end
               ACT_DELETE: begin
                  if (sts.hit) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     cmd.ptr_inc = 1'b1;
                  end
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (sts.last_shift) begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESPOND;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESPOND);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the access-list entry table: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
   import alet_pkg::*;

   localparam int TBL_DEPTH   = 16;
   localparam int CNT_W       = $clog2(TBL_DEPTH + 1);
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1300;

   // Tags that the package does not name.
   localparam logic [2:0] TAG_OWNER_USER = 3'd0;
   localparam logic [2:0] TAG_OTHER      = 3'd5;
   localparam logic [2:0] TAG_SPARE_LO   = 3'd6;
   localparam logic [2:0] TAG_SPARE_HI   = 3'd7;

   typedef struct {
      action_type  act;
      logic [2:0]  tag;
      logic [31:0] id;
      logic [2:0]  perms;
   } request_type;

   typedef struct {
      status_code_type status;
      logic [CNT_W-1:0] count;
      logic [2:0]       mask;
      logic             needed;
   } outcome_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_action;
   logic [2:0]       req_entry_tag;
   logic [31:0]      req_entry_id;
   logic [2:0]       req_entry_perms;
   logic             rsp_valid;
   logic [1:0]       rsp_status;
   logic [CNT_W-1:0] rsp_entry_count;
   logic [2:0]       rsp_mask_perms;
   logic             rsp_mask_needed;

   access_list_entry_table #(
      .MAX_ENTRIES(TBL_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_entry_tag(req_entry_tag),
      .req_entry_id(req_entry_id),
      .req_entry_perms(req_entry_perms),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_mask_perms(rsp_mask_perms),
      .rsp_mask_needed(rsp_mask_needed)
   );

   request_type pending_reqs[$];
   outcome_type expected_outcomes[$];

   // Shadow copy of the entry table.
   logic [2:0]  tbl_tag  [TBL_DEPTH];
   logic [31:0] tbl_id   [TBL_DEPTH];
   logic [2:0]  tbl_perm [TBL_DEPTH];
   int          tbl_count;

   int  error_count;
   int  idle_cycles;
   bit  req_taken;
   int  gap_left;
   int  calm_left;
   int  n_add, n_delete, n_calc, n_clear, n_full, n_nomatch, n_mask_drop;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit slot_hit(int slot, logic [2:0] tag, logic [31:0] id);
      if (tbl_tag[slot] != tag) return 1'b0;
      if (tag == TAG_NAMED_USER || tag == TAG_NAMED_GROUP) return tbl_id[slot] == id;
      return 1'b1;
   endfunction

   function automatic status_code_type tbl_add(logic [2:0] tag, logic [31:0] id,
                                               logic [2:0] perms);
      for (int i = 0; i < tbl_count; i++) begin
         if (slot_hit(i, tag, id)) begin
            tbl_perm[i] = perms;
            return STATUS_OK;
         end
      end
      if (tbl_count >= TBL_DEPTH) return STATUS_FULL;
      tbl_tag[tbl_count]  = tag;
      tbl_id[tbl_count]   = id;
      tbl_perm[tbl_count] = perms;
      tbl_count++;
      return STATUS_OK;
   endfunction

   function automatic status_code_type tbl_delete(logic [2:0] tag, logic [31:0] id);
      for (int i = 0; i < tbl_count; i++) begin
         if (slot_hit(i, tag, id)) begin
            for (int j = i; j + 1 < tbl_count; j++) begin
               tbl_tag[j]  = tbl_tag[j + 1];
               tbl_id[j]   = tbl_id[j + 1];
               tbl_perm[j] = tbl_perm[j + 1];
            end
            tbl_count--;
            return STATUS_OK;
         end
      end
      return STATUS_NOMATCH;
   endfunction

   // Applies one request to the shadow table and returns the response it should produce.
   function automatic outcome_type predict_outcome(action_type act, logic [2:0] tag,
                                                   logic [31:0] id, logic [2:0] perms);
      outcome_type res;
      res.status = STATUS_OK;
      res.mask   = 3'd0;
      res.needed = 1'b0;
      case (act)
         ACT_ADD: begin
            res.status = tbl_add(tag, id, perms);
            n_add++;
         end
         ACT_DELETE: begin
            res.status = tbl_delete(tag, id);
            n_delete++;
         end
         ACT_CALC: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_tag[i] == TAG_NAMED_USER || tbl_tag[i] == TAG_OWNING_GROUP ||
                   tbl_tag[i] == TAG_NAMED_GROUP) begin
                  res.mask   = res.mask | tbl_perm[i];
                  res.needed = 1'b1;
               end
            end
            // A mask entry that does not fit is dropped silently.
            if (res.needed && tbl_add(TAG_MASK, 32'd0, res.mask) == STATUS_FULL)
               n_mask_drop++;
            n_calc++;
         end
         default: begin
            tbl_count = 0;
            n_clear++;
         end
      endcase
      if (res.status == STATUS_FULL) n_full++;
      if (res.status == STATUS_NOMATCH) n_nomatch++;
      res.count = CNT_W'(tbl_count);
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic push_req(action_type act, logic [2:0] tag, logic [31:0] id,
                           logic [2:0] perms);
      request_type r;
      r.act   = act;
      r.tag   = tag;
      r.id    = id;
      r.perms = perms;
      pending_reqs.push_back(r);
   endtask

   // Ids come mostly from a small pool so that lookups hit often.
   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5, 6, 7: return $urandom_range(2, 5);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_random(int add_w);
      int r;
      action_type act;
      r = $urandom_range(0, 99);
      if (r < add_w) act = ACT_ADD;
      else if (r < add_w + (100 - add_w) * 6 / 10) act = ACT_DELETE;
      else if (r < 97) act = ACT_CALC;
      else act = ACT_CLEAR;
      push_req(act, 3'($urandom_range(0, 7)), pick_id(), 3'($urandom_range(0, 7)));
   endtask

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Driver: presents the next pending request at the falling edge.
   always @(negedge clock) begin
      request_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_action      <= nxt.act;
            req_entry_tag   <= nxt.tag;
            req_entry_id    <= nxt.id;
            req_entry_perms <= nxt.perms;
            start           <= 1'b1;
            gap_left        <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks responses and predicts each accepted request at the rising edge.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                        $time, rsp_status, rsp_entry_count);
               error_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("entry_count", want.count, rsp_entry_count);
               check_field("mask_perms", want.mask, rsp_mask_perms);
               check_field("mask_needed", want.needed, rsp_mask_needed);
            end
         end
         if (start && !busy)
            expected_outcomes.push_back(predict_outcome(action_type'(req_action),
               req_entry_tag, req_entry_id, req_entry_perms));
         req_taken   <= start && !busy;
         idle_cycles <= (rsp_valid || (start && !busy)) ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog: ends the run if no transfer happens for too long.
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int n;
      int base;
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = 2'd0;
      req_entry_tag   = 3'd0;
      req_entry_id    = 32'd0;
      req_entry_perms = 3'd0;
      tbl_count   = 0;
      error_count = 0;
      idle_cycles = 0;
      req_taken   = 1'b0;
      gap_left    = 0;
      calm_left   = 0;
      n_add = 0; n_delete = 0; n_calc = 0; n_clear = 0;
      n_full = 0; n_nomatch = 0; n_mask_drop = 0;

      // Empty-table cases first, then each tag and the update, shift and mask paths.
      push_req(ACT_CALC, TAG_NAMED_USER, 32'hFFFF_FFFF, 3'd7);
      push_req(ACT_DELETE, TAG_OWNER_USER, 32'd0, 3'd0);
      push_req(ACT_CLEAR, TAG_SPARE_HI, 32'd0, 3'd7);
      push_req(ACT_ADD, TAG_OWNER_USER, 32'hFFFF_FFFF, 3'd7);
      push_req(ACT_ADD, TAG_NAMED_USER, 32'd0, 3'd0);
      push_req(ACT_ADD, TAG_NAMED_USER, 32'hFFFF_FFFF, 3'd5);
      push_req(ACT_ADD, TAG_OWNING_GROUP, 32'h5555_5555, 3'd2);
      push_req(ACT_ADD, TAG_NAMED_GROUP, 32'h8000_0000, 3'd1);
      push_req(ACT_ADD, TAG_OTHER, 32'hAAAA_AAAA, 3'd4);
      push_req(ACT_ADD, TAG_SPARE_LO, 32'd9, 3'd6);
      push_req(ACT_ADD, TAG_SPARE_HI, 32'd3, 3'd3);
      push_req(ACT_ADD, TAG_NAMED_USER, 32'd0, 3'd3);
      push_req(ACT_ADD, TAG_OWNER_USER, 32'h0001_2345, 3'd1);
      push_req(ACT_CALC, TAG_OTHER, 32'h1234_5678, 3'd0);
      push_req(ACT_ADD, TAG_NAMED_GROUP, 32'd7, 3'd4);
      push_req(ACT_CALC, TAG_MASK, 32'd0, 3'd5);
      push_req(ACT_DELETE, TAG_NAMED_USER, 32'd1, 3'd0);
      push_req(ACT_DELETE, TAG_NAMED_USER, 32'hFFFF_FFFF, 3'd7);
      push_req(ACT_DELETE, TAG_SPARE_HI, 32'hDEAD_BEEF, 3'd2);
      push_req(ACT_DELETE, TAG_OWNER_USER, 32'd4, 3'd7);
      push_req(ACT_DELETE, TAG_MASK, 32'd11, 3'd1);
      push_req(ACT_CALC, TAG_OWNER_USER, 32'd0, 3'd0);
      push_req(ACT_CLEAR, TAG_OWNER_USER, 32'hFFFF_FFFF, 3'd0);
      push_req(ACT_CALC, TAG_NAMED_GROUP, 32'd0, 3'd7);
      push_req(ACT_ADD, TAG_MASK, 32'hFFFF_FFFF, 3'd7);

      // Random part: fill runs push the table toward full, mixed runs churn it.
      while (pending_reqs.size() < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 30) begin
            push_req(ACT_CLEAR, 3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)));
            n    = $urandom_range(12, TBL_DEPTH + 4);
            base = $urandom;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 9) < 7)
                  push_req(ACT_ADD, $urandom_range(0, 1) ? TAG_NAMED_USER : TAG_NAMED_GROUP,
                           base + i, 3'($urandom_range(0, 7)));
               else
                  push_random(100);
            end
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++) push_random(50);
         end else begin
            n    = $urandom_range(20, 40);
            base = $urandom_range(35, 70);
            for (int i = 0; i < n; i++) push_random(base);
         end
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || start || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Covered %0d adds, %0d deletes, %0d mask calculations and %0d clears.",
               n_add, n_delete, n_calc, n_clear);
      $display("Saw %0d full-table adds, %0d deletes without a match, %0d dropped mask entries.",
               n_full, n_nomatch, n_mask_drop);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
